// ===== sv/ufr_pkg.sv =====
// ufr_pkg: shared types and constants for the uart frame receiver
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_HDR2 = 4'd1,
    PH_CMDH = 4'd2,
    PH_CMDL = 4'd3,
    PH_LENL = 4'd4,
    PH_LENH = 4'd5,
    PH_DATA = 4'd6,
    PH_CR1  = 4'd7,
    PH_CR2  = 4'd8,
    PH_SUM  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_MORE     = 3'd0,
    ST_FRAME_OK = 3'd1,
    ST_CSUM_ERR = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LINE_ERR = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  received_checksum;
    logic [7:0]  code_second;
    logic [7:0]  code_first;
    logic [15:0] payload_length;
    logic [7:0]  command_low;
    logic [7:0]  command_high;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    status_t     status;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/ufr_parser.sv =====
// ufr_parser: frame state machine and per-byte result logic
`timescale 1ns / 1ps
`default_nettype none

module ufr_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        line_error,
  input  wire logic [15:0] max_payload,
  output ufr_pkg::res_t    res
);
  import ufr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  cmdh_r, cmdh_nxt;
  logic [7:0]  cmdl_r, cmdl_nxt;
  logic [7:0]  code1_r, code1_nxt;
  logic [7:0]  code2_r, code2_nxt;

  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic        room;

  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = len_r | {rx_byte, 8'h00};
  assign room     = cnt_r < max_payload;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (!line_error) begin
      unique case (phase_r)
        PH_HUNT: phase_nxt = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        PH_HDR2: phase_nxt = (rx_byte == HDR_SECOND) ? PH_CMDH : PH_HUNT;
        PH_CMDH: phase_nxt = PH_CMDL;
        PH_CMDL: phase_nxt = PH_LENL;
        PH_LENL: phase_nxt = PH_LENH;
        PH_LENH: phase_nxt = (len_full != 16'd0) ? PH_DATA : PH_CR1;
        PH_DATA: begin
          if (!room) phase_nxt = PH_HUNT;
          else if (cnt_inc == len_r) phase_nxt = PH_CR1;
          else phase_nxt = PH_DATA;
        end
        PH_CR1:  phase_nxt = PH_CR2;
        PH_CR2:  phase_nxt = PH_SUM;
        PH_SUM:  phase_nxt = PH_HUNT;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    cmdh_nxt  = cmdh_r;
    cmdl_nxt  = cmdl_r;
    code1_nxt = code1_r;
    code2_nxt = code2_r;
    res.status            = ST_MORE;
    res.payload_valid     = 1'b0;
    res.payload_byte      = 8'h00;
    res.payload_index     = 16'h0000;
    res.received_checksum = 8'h00;
    if (line_error) begin
      res.status = ST_LINE_ERR;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          xor_nxt   = (rx_byte == HDR_FIRST) ? rx_byte : 8'h00;
          cnt_nxt   = 16'h0000;
          len_nxt   = 16'h0000;
          cmdh_nxt  = 8'h00;
          cmdl_nxt  = 8'h00;
          code1_nxt = 8'h00;
          code2_nxt = 8'h00;
        end
        PH_HDR2: begin
          if (rx_byte == HDR_SECOND) xor_nxt = xor_r ^ rx_byte;
        end
        PH_CMDH: begin
          cmdh_nxt = rx_byte;
          xor_nxt  = xor_r ^ rx_byte;
        end
        PH_CMDL: begin
          cmdl_nxt = rx_byte;
          xor_nxt  = xor_r ^ rx_byte;
        end
        PH_LENL: begin
          len_nxt = {8'h00, rx_byte};
          xor_nxt = xor_r ^ rx_byte;
        end
        PH_LENH: begin
          len_nxt = len_full;
          xor_nxt = xor_r ^ rx_byte;
        end
        PH_DATA: begin
          if (room) begin
            xor_nxt           = xor_r ^ rx_byte;
            cnt_nxt           = cnt_inc;
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
            res.payload_index = cnt_r;
          end else begin
            res.status = ST_OVERFLOW;
          end
        end
        PH_CR1: begin
          code1_nxt = rx_byte;
          xor_nxt   = xor_r ^ rx_byte;
        end
        PH_CR2: begin
          code2_nxt = rx_byte;
          xor_nxt   = xor_r ^ rx_byte;
        end
        PH_SUM: begin
          res.received_checksum = rx_byte;
          res.status = (rx_byte == xor_r) ? ST_FRAME_OK : ST_CSUM_ERR;
        end
        default: ;
      endcase
    end
    res.command_high   = cmdh_nxt;
    res.command_low    = cmdl_nxt;
    res.payload_length = len_nxt;
    res.code_first     = code1_nxt;
    res.code_second    = code2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      xor_r   <= 8'h00;
      cnt_r   <= 16'h0000;
      len_r   <= 16'h0000;
      cmdh_r  <= 8'h00;
      cmdl_r  <= 8'h00;
      code1_r <= 8'h00;
      code2_r <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      cmdh_r  <= cmdh_nxt;
      cmdl_r  <= cmdl_nxt;
      code1_r <= code1_nxt;
      code2_r <= code2_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/uart_frame_receiver.sv =====
// uart_frame_receiver: top level of the framed response parser
`timescale 1ns / 1ps
`default_nettype none

// Parses a byte stream of frames laid out as 0xAA 0x55, command high and low,
// a little-endian 16-bit length, the payload, two response code bytes and an
// XOR checksum over all earlier bytes, and returns exactly one result per
// input transaction. One byte is taken every cycle while the result side
// keeps up; each byte passes an input register, then a result register,
// and the rate is set by the frame state machine, which updates once per byte.
// A byte flagged in in_tuser as a line error reports status 4 and leaves the
// parser untouched. max_payload resets to 65535 and is written on cfg_*.
module uart_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  input  wire logic        in_tuser,   // line_error
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // payload_byte, payload_index, command_high, command_low, payload_length,
  // code_first, code_second, received_checksum
  output      logic [79:0] out_tdata,
  output      logic [3:0]  out_tuser,  // status[2:0], payload_valid
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data    // max_payload
);
  import ufr_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_err_r;
  logic        out_valid_r;
  res_t        res, res_r;
  logic [15:0] max_payload_r;
  logic        advance;
  logic        step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_err_r  <= in_tuser;
    end
  end

  ufr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (in_byte_r),
    .line_error  (in_err_r),
    .max_payload (max_payload_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.payload_valid, res_r.status};
  assign out_tdata  = {res_r.received_checksum, res_r.code_second, res_r.code_first,
                       res_r.payload_length, res_r.command_low, res_r.command_high,
                       res_r.payload_index, res_r.payload_byte};

endmodule

`default_nettype wire

// ===== sv/ufr_checker.sv =====
// ufr_checker: port-level assertions for the uart frame receiver
`timescale 1ns / 1ps
`default_nettype none

module ufr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [3:0]  out_tuser
);
  import ufr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] != 3'd5) && (out_tuser[2:0] != 3'd6)
                   && (out_tuser[2:0] != 3'd7))
    else $error("status code out of range");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == ST_MORE)
    else $error("payload byte with final status");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata[23:0] == 24'h000000)
    else $error("payload fields set without payload_valid");

  a_checksum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] != ST_FRAME_OK) && (out_tuser[2:0] != ST_CSUM_ERR)
      |-> out_tdata[79:72] == 8'h00)
    else $error("checksum reported outside frame end");

endmodule

bind uart_frame_receiver ufr_checker u_ufr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/tb_uart_frame_receiver.sv =====
// tb_uart_frame_receiver: self-checking stream testbench for the uart frame receiver
`timescale 1ns / 1ps

module tb_uart_frame_receiver;
  import ufr_pkg::*;

  typedef struct {
    status_t     status;
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic [15:0] pay_idx;
    logic [7:0]  cmd_hi;
    logic [7:0]  cmd_lo;
    logic [15:0] frame_len;
    logic [7:0]  code1;
    logic [7:0]  code2;
    logic [7:0]  rx_sum;
  } report_t;

  typedef struct {
    logic [7:0] rx;
    logic       lerr;
    logic       pinned;
    status_t    status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  // parser shadow state
  phase_t      sh_phase;
  logic [7:0]  sh_xor;
  logic [15:0] sh_count;
  logic [15:0] sh_len;
  logic [7:0]  sh_cmd_hi;
  logic [7:0]  sh_cmd_lo;
  logic [7:0]  sh_code1;
  logic [7:0]  sh_code2;
  logic [15:0] sh_max_payload;

  report_t     parser_reports[$];
  dir_row_t    dir_rows[28];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned frames_ok = 0;
  int unsigned csum_errs = 0;
  int unsigned overflows = 0;
  int unsigned line_errs = 0;
  int unsigned payload_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  uart_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_uart_frame_receiver: errors");
    $finish;
  end

  function automatic void shadow_reset();
    sh_phase = PH_HUNT;
    sh_xor = 8'h00;
    sh_count = 16'h0000;
    sh_len = 16'h0000;
    sh_cmd_hi = 8'h00;
    sh_cmd_lo = 8'h00;
    sh_code1 = 8'h00;
    sh_code2 = 8'h00;
    sh_max_payload = 16'hFFFF;
  endfunction

  // advance the shadow parser by one received byte
  function automatic report_t parse_rx_byte(logic [7:0] b, logic lerr);
    report_t r;
    r.status = ST_MORE;
    r.pay_valid = 1'b0;
    r.pay_byte = 8'h00;
    r.pay_idx = 16'h0000;
    r.rx_sum = 8'h00;
    if (lerr) begin
      r.status = ST_LINE_ERR;
    end else begin
      case (sh_phase)
        PH_HUNT: begin
          sh_xor = 8'h00;
          sh_count = 16'h0000;
          sh_len = 16'h0000;
          sh_cmd_hi = 8'h00;
          sh_cmd_lo = 8'h00;
          sh_code1 = 8'h00;
          sh_code2 = 8'h00;
          if (b == HDR_FIRST) begin
            sh_xor = b;
            sh_phase = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (b == HDR_SECOND) begin
            sh_xor ^= b;
            sh_phase = PH_CMDH;
          end else begin
            sh_phase = PH_HUNT;
          end
        end
        PH_CMDH: begin
          sh_cmd_hi = b;
          sh_xor ^= b;
          sh_phase = PH_CMDL;
        end
        PH_CMDL: begin
          sh_cmd_lo = b;
          sh_xor ^= b;
          sh_phase = PH_LENL;
        end
        PH_LENL: begin
          sh_len = {8'h00, b};
          sh_xor ^= b;
          sh_phase = PH_LENH;
        end
        PH_LENH: begin
          sh_len = {b, sh_len[7:0]};
          sh_xor ^= b;
          sh_phase = (sh_len != 16'h0000) ? PH_DATA : PH_CR1;
        end
        PH_DATA: begin
          if (sh_count < sh_max_payload) begin
            sh_xor ^= b;
            r.pay_valid = 1'b1;
            r.pay_byte = b;
            r.pay_idx = sh_count;
            sh_count = sh_count + 16'd1;
            if (sh_count == sh_len) sh_phase = PH_CR1;
          end else begin
            r.status = ST_OVERFLOW;
            sh_phase = PH_HUNT;
          end
        end
        PH_CR1: begin
          sh_code1 = b;
          sh_xor ^= b;
          sh_phase = PH_CR2;
        end
        PH_CR2: begin
          sh_code2 = b;
          sh_xor ^= b;
          sh_phase = PH_SUM;
        end
        PH_SUM: begin
          r.rx_sum = b;
          r.status = (b == sh_xor) ? ST_FRAME_OK : ST_CSUM_ERR;
          sh_phase = PH_HUNT;
        end
        default: begin
          sh_phase = PH_HUNT;
        end
      endcase
    end
    r.cmd_hi = sh_cmd_hi;
    r.cmd_lo = sh_cmd_lo;
    r.frame_len = sh_len;
    r.code1 = sh_code1;
    r.code2 = sh_code2;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic compare_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parser_reports.size() == 0) begin
        report_mismatch("transaction with nothing pending", 16'h0, 16'h0);
      end else begin
        want = parser_reports.pop_front();
        compare_field("status", {13'h0, out_tuser[2:0]}, {13'h0, want.status});
        compare_field("payload_valid", {15'h0, out_tuser[3]}, {15'h0, want.pay_valid});
        compare_field("payload_byte", {8'h0, out_tdata[7:0]}, {8'h0, want.pay_byte});
        compare_field("payload_index", out_tdata[23:8], want.pay_idx);
        compare_field("command_high", {8'h0, out_tdata[31:24]}, {8'h0, want.cmd_hi});
        compare_field("command_low", {8'h0, out_tdata[39:32]}, {8'h0, want.cmd_lo});
        compare_field("payload_length", out_tdata[55:40], want.frame_len);
        compare_field("code_first", {8'h0, out_tdata[63:56]}, {8'h0, want.code1});
        compare_field("code_second", {8'h0, out_tdata[71:64]}, {8'h0, want.code2});
        compare_field("received_checksum", {8'h0, out_tdata[79:72]}, {8'h0, want.rx_sum});
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(logic [7:0] b, logic lerr, logic pinned, status_t pin_status);
    report_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= lerr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = parse_rx_byte(b, lerr);
    if (pinned) r.status = pin_status;
    case (r.status)
      ST_FRAME_OK: frames_ok++;
      ST_CSUM_ERR: csum_errs++;
      ST_OVERFLOW: overflows++;
      ST_LINE_ERR: line_errs++;
      default: ;
    endcase
    if (r.pay_valid) payload_seen++;
    parser_reports.push_back(r);
    bytes_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (parser_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_payload(logic [15:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sh_max_payload = v;
    cfg_writes++;
  endtask

  // received byte with an occasional line error ahead of it
  task automatic send_link_byte(logic [7:0] b);
    if ($urandom_range(99) < 4) send_byte(8'($urandom_range(255)), 1'b1, 1'b0, ST_MORE);
    send_byte(b, 1'b0, 1'b0, ST_MORE);
  endtask

  function automatic logic [15:0] pick_length(logic [15:0] lim);
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(99);
    if (r < 65 || lim > 60) return 16'($urandom_range(6));
    if (r < 85) begin
      lo = (lim == 0) ? 0 : lim - 1;
      hi = lim + 1;
      return 16'($urandom_range(hi, lo));
    end
    if (r < 93) return 16'($urandom_range(40, 7));
    return 16'hFFFF;
  endfunction

  task automatic send_frame();
    logic [7:0]  fb;
    logic [7:0]  sum;
    logic [15:0] len;
    int unsigned body;
    len = pick_length(sh_max_payload);
    body = (len > sh_max_payload + 2) ? sh_max_payload + 2 : len;
    sum = HDR_FIRST ^ HDR_SECOND;
    send_link_byte(HDR_FIRST);
    send_link_byte(HDR_SECOND);
    repeat (2) begin
      fb = 8'($urandom_range(255));
      sum ^= fb;
      send_link_byte(fb);
    end
    sum ^= len[7:0] ^ len[15:8];
    send_link_byte(len[7:0]);
    send_link_byte(len[15:8]);
    repeat (body) begin
      fb = 8'($urandom_range(255));
      sum ^= fb;
      send_link_byte(fb);
    end
    repeat (2) begin
      fb = 8'($urandom_range(255));
      sum ^= fb;
      send_link_byte(fb);
    end
    if ($urandom_range(99) < 20) sum ^= 8'($urandom_range(255, 1));
    send_link_byte(sum);
  endtask

  initial begin
    int unsigned kind;
    int unsigned phase_start;
    dir_rows = '{
      '{8'hAA, 1'b0, 1'b0, ST_MORE},
      '{8'hAA, 1'b0, 1'b1, ST_MORE},      // bad second header byte
      '{8'hAA, 1'b0, 1'b0, ST_MORE},
      '{8'h55, 1'b0, 1'b0, ST_MORE},
      '{8'hFF, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},      // zero length skips payload
      '{8'hFF, 1'b0, 1'b0, ST_MORE},
      '{8'h80, 1'b0, 1'b0, ST_MORE},
      '{8'h7F, 1'b0, 1'b1, ST_FRAME_OK},
      '{8'hAA, 1'b0, 1'b0, ST_MORE},
      '{8'h55, 1'b0, 1'b0, ST_MORE},
      '{8'h01, 1'b0, 1'b0, ST_MORE},
      '{8'h80, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'hFF, 1'b1, 1'b1, ST_LINE_ERR},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'hFF, 1'b0, 1'b0, ST_MORE},
      '{8'h18, 1'b0, 1'b1, ST_CSUM_ERR},
      '{8'hAA, 1'b0, 1'b0, ST_MORE},
      '{8'h55, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h01, 1'b0, 1'b0, ST_MORE},
      '{8'h00, 1'b0, 1'b0, ST_MORE},
      '{8'h42, 1'b0, 1'b1, ST_OVERFLOW}   // payload beyond max_payload of zero
    };
    shadow_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_max_payload(16'h0000);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx, dir_rows[i].lerr, dir_rows[i].pinned, dir_rows[i].status);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_max_payload(16'hFFFF);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_max_payload(16'd4);
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          write_max_payload(16'($urandom_range(10, 1)));
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          write_max_payload(16'd12);
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 180) begin
        if ($urandom_range(29) == 0) drain_results();
        kind = $urandom_range(99);
        if (kind < 80) begin
          send_frame();
        end else if (kind < 88) begin
          send_link_byte(HDR_FIRST);
          send_link_byte(8'($urandom_range(255, 86)));
          repeat ($urandom_range(3)) send_link_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(4, 1)) send_link_byte(8'($urandom_range(255)));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes over %0d max_payload settings, idle and stall phases",
             bytes_sent, cfg_writes);
    $display("frames ok %0d, checksum errors %0d, overflows %0d, line errors %0d, payload %0d",
             frames_ok, csum_errs, overflows, line_errs, payload_seen);
    if (mismatches == 0) begin
      $display("tb_uart_frame_receiver: clean");
    end else begin
      $display("tb_uart_frame_receiver: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ufr_pkg.sv
sv/ufr_parser.sv
sv/uart_frame_receiver.sv
sv/ufr_checker.sv
tb/tb_uart_frame_receiver.sv
